>>> hdl/rrva_pkg.sv
// Shared types and constants for the residue vector ALU.
// Used by rrva_modred, rrva_lane and rns_residue_vector_alu_unit; no dependencies.
`default_nettype none
package rrva_pkg;

   localparam int unsigned LANE_SLOTS    = 4;
   localparam int unsigned NUM_LANES_DEF = 4;
   localparam int unsigned RES_W         = 32;
   localparam int unsigned MOD_W         = RES_W + 1;  // zero modulus reads as 2^32
   localparam int unsigned CMD_W         = 2;

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SUB   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SCALE = 2'd2;

   // Registers through one lane: coefficient reduction, multiply, product
   // reduction, output register.
   localparam int unsigned LANE_LAT = RES_W + 1 + 2 * RES_W + 1;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [RES_W-1:0] left_res0;
      logic [RES_W-1:0] left_res1;
      logic [RES_W-1:0] left_res2;
      logic [RES_W-1:0] left_res3;
      logic [RES_W-1:0] right_res0;
      logic [RES_W-1:0] right_res1;
      logic [RES_W-1:0] right_res2;
      logic [RES_W-1:0] right_res3;
      logic signed [RES_W-1:0] scale_coef;
   } req_type;

   typedef struct packed {
      logic [RES_W-1:0] result_res0;
      logic [RES_W-1:0] result_res1;
      logic [RES_W-1:0] result_res2;
      logic [RES_W-1:0] result_res3;
   } rsp_type;

endpackage
`default_nettype wire

>>> hdl/rrva_modred.sv
// Pipelined restoring reduction: dividend mod modulus, one dividend bit per stage.
// Depends on rrva_pkg. Carries a sideband word alongside the dividend.
`default_nettype none
module rrva_modred #(
   parameter int unsigned DW = 32,
   parameter int unsigned SW = 8
) (
   input  wire logic                        clock,
   input  wire logic [DW-1:0]               dividend,
   input  wire logic [SW-1:0]               side_in,
   input  wire logic [rrva_pkg::MOD_W-1:0]  modulus,
   output logic      [rrva_pkg::MOD_W-1:0]  rem_out,
   output logic      [SW-1:0]               side_out
);
   import rrva_pkg::*;

   logic [MOD_W-1:0] rem_ff  [DW];
   logic [DW-1:0]    dv_ff   [DW];
   logic [SW-1:0]    side_ff [DW];

   for (genvar s = 0; s < DW; s++) begin : g_stage
      logic [MOD_W-1:0] rem_prev;
      logic [DW-1:0]    dv_prev;
      logic [SW-1:0]    side_prev;
      logic [MOD_W:0]   trial;
      logic [MOD_W-1:0] rem_in;

      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign dv_prev   = dividend;
         assign side_prev = side_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign dv_prev   = dv_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      always_comb begin
         trial = {rem_prev, dv_prev[DW-1]};
         if (trial >= {1'b0, modulus}) begin
            trial = trial - {1'b0, modulus};
         end
         rem_in = trial[MOD_W-1:0];
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         dv_ff[s]   <= {dv_prev[DW-2:0], 1'b0};
         side_ff[s] <= side_prev;
      end
   end

   assign rem_out  = rem_ff[DW-1];
   assign side_out = side_ff[DW-1];

endmodule
`default_nettype wire

>>> hdl/rrva_lane.sv
// One residue lane: add, subtract, signed scale modulo the lane modulus.
// Depends on rrva_pkg and rrva_modred.
`default_nettype none
module rrva_lane (
   input  wire logic                              clock,
   input  wire logic [rrva_pkg::CMD_W-1:0]        cmd,
   input  wire logic [rrva_pkg::RES_W-1:0]        left_res,
   input  wire logic [rrva_pkg::RES_W-1:0]        right_res,
   input  wire logic signed [rrva_pkg::RES_W-1:0] scale_coef,
   input  wire logic [rrva_pkg::RES_W-1:0]        modulus_cfg,
   output logic      [rrva_pkg::RES_W-1:0]        result_res
);
   import rrva_pkg::*;

   localparam int unsigned S1_W = CMD_W + 1 + 2 * RES_W;
   localparam int unsigned S2_W = CMD_W + 1 + RES_W;

   logic [MOD_W-1:0] mod_full;
   logic             neg;
   logic [RES_W-1:0] mag;
   logic [MOD_W-1:0] mag_rem;
   logic [S1_W-1:0]  s1_side;

   logic [CMD_W-1:0] s1_cmd;
   logic             s1_neg;
   logic [RES_W-1:0] s1_a;
   logic [RES_W-1:0] s1_b;

   logic [2*RES_W-1:0] prod_in, prod_ff;
   logic [RES_W-1:0]   aux_in;
   logic [S2_W-1:0]    side2_in, side2_ff;

   logic [MOD_W-1:0] p_rem;
   logic [S2_W-1:0]  s2_side;
   logic [CMD_W-1:0] s2_cmd;
   logic             s2_neg;
   logic [RES_W-1:0] s2_aux;
   logic [MOD_W-1:0] neg_fix;

   logic [RES_W-1:0] result_in, result_ff;

   assign mod_full = (modulus_cfg == '0) ? {1'b1, {RES_W{1'b0}}} : {1'b0, modulus_cfg};
   assign neg      = scale_coef[RES_W-1];
   // Negating the most negative value wraps to itself, which is the right magnitude.
   assign mag      = neg ? (~scale_coef + 1'b1) : scale_coef;

   rrva_modred #(.DW(RES_W), .SW(S1_W)) u_coef_red (
      .clock    (clock),
      .dividend (mag),
      .side_in  ({cmd, neg, left_res, right_res}),
      .modulus  (mod_full),
      .rem_out  (mag_rem),
      .side_out (s1_side)
   );

   assign {s1_cmd, s1_neg, s1_a, s1_b} = s1_side;

   always_comb begin
      case (s1_cmd)
         CMD_ADD: begin
            prod_in = {{(RES_W-1){1'b0}}, {1'b0, s1_a} + {1'b0, s1_b}};
            aux_in  = s1_a;
         end
         CMD_SUB: begin
            prod_in = '0;
            aux_in  = (s1_a < s1_b) ? (s1_a + mod_full[RES_W-1:0] - s1_b) : (s1_a - s1_b);
         end
         CMD_SCALE: begin
            prod_in = s1_a * mag_rem[RES_W-1:0];
            aux_in  = s1_a;
         end
         default: begin
            prod_in = '0;
            aux_in  = s1_a;
         end
      endcase
      side2_in = {s1_cmd, s1_neg, aux_in};
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      side2_ff <= side2_in;
   end

   rrva_modred #(.DW(2*RES_W), .SW(S2_W)) u_prod_red (
      .clock    (clock),
      .dividend (prod_ff),
      .side_in  (side2_ff),
      .modulus  (mod_full),
      .rem_out  (p_rem),
      .side_out (s2_side)
   );

   assign {s2_cmd, s2_neg, s2_aux} = s2_side;
   assign neg_fix = mod_full - p_rem;

   always_comb begin
      case (s2_cmd)
         CMD_ADD:   result_in = p_rem[RES_W-1:0];
         CMD_SUB:   result_in = s2_aux;
         CMD_SCALE: result_in = (s2_neg && p_rem != '0) ? neg_fix[RES_W-1:0]
                                                         : p_rem[RES_W-1:0];
         default:   result_in = s2_aux;
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result_res = result_ff;

endmodule
`default_nettype wire

>>> hdl/rns_residue_vector_alu_unit.sv
// Throughput: one transaction per cycle; each lane is a fully pipelined chain of
// 32 coefficient reduction stages, a multiply stage and 64 product reduction stages.
// busy follows reset; the receiver cannot stall, so results flow at the input rate.
// Reset (synchronous, active high) clears the strobe pipeline and sets moduli to 2.
// Depends on rrva_pkg, rrva_lane and rrva_modred.
`default_nettype none
module rns_residue_vector_alu_unit #(
   parameter int unsigned NUM_LANES = rrva_pkg::NUM_LANES_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire rrva_pkg::req_type       req_data,
   output logic                         rsp_valid,
   output rrva_pkg::rsp_type            rsp_data,
   input  wire logic                    csr_we,
   input  wire logic [1:0]              csr_index,
   input  wire logic [rrva_pkg::RES_W-1:0] csr_data
);
   import rrva_pkg::*;

   logic [RES_W-1:0] mod_ff [LANE_SLOTS];
   logic [LANE_LAT-1:0] valid_pipe_ff;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;
   logic accept;

   logic [RES_W-1:0] left_v  [LANE_SLOTS];
   logic [RES_W-1:0] right_v [LANE_SLOTS];
   logic [RES_W-1:0] res_v   [LANE_SLOTS];

   assign busy   = reset;
   assign accept = start && !busy;

   assign left_v[0]  = req_data.left_res0;
   assign left_v[1]  = req_data.left_res1;
   assign left_v[2]  = req_data.left_res2;
   assign left_v[3]  = req_data.left_res3;
   assign right_v[0] = req_data.right_res0;
   assign right_v[1] = req_data.right_res1;
   assign right_v[2] = req_data.right_res2;
   assign right_v[3] = req_data.right_res3;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_SLOTS; i++) begin
            mod_ff[i] <= RES_W'(2);
         end
      end else if (csr_we) begin
         mod_ff[csr_index] <= csr_data;
      end
   end

   for (genvar l = 0; l < LANE_SLOTS; l++) begin : g_lane
      if (l < NUM_LANES) begin : g_on
         rrva_lane u_lane (
            .clock       (clock),
            .cmd         (req_data.cmd),
            .left_res    (left_v[l]),
            .right_res   (right_v[l]),
            .scale_coef  (req_data.scale_coef),
            .modulus_cfg (mod_ff[l]),
            .result_res  (res_v[l])
         );
      end else begin : g_off
         assign res_v[l] = '0;
      end
   end

   // Merge lane results into one transaction.
   always_comb begin
      rsp_data_in.result_res0 = res_v[0];
      rsp_data_in.result_res1 = res_v[1];
      rsp_data_in.result_res2 = res_v[2];
      rsp_data_in.result_res3 = res_v[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pipe_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_pipe_ff <= {valid_pipe_ff[LANE_LAT-2:0], accept};
         rsp_valid_ff  <= valid_pipe_ff[LANE_LAT-1];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept, LANE_LAT + 1))
      else $error("result strobe without matching transaction");

   a_no_busy: assert property (@(posedge clock)
      !reset |-> !busy)
      else $error("busy raised outside reset");

   a_csr_write: assert property (@(posedge clock)
      (csr_we && !reset) |=> (mod_ff[$past(csr_index)] == $past(csr_data)))
      else $error("modulus register write lost");

endmodule
`default_nettype wire
